// ===== design/epm_pkg.sv =====
`default_nettype none

package epm_pkg;

    // Parameter defaults
    localparam int ADC_BITS_DEF    = 10;
    localparam int ENERGY_BITS_DEF = 48;

    // Field widths
    localparam int SAMPLE_W     = 10;
    localparam int NOW_W        = 32;
    localparam int PERIOD_W     = 16;
    localparam int ALPHA_W      = 17;
    localparam int COEF_W       = 24;
    localparam int VOLT_W       = 24;
    localparam int WATT_W       = 32;
    localparam int ENERGY_OUT_W = 48;
    localparam int FRAC_W       = 16;

    // Shared multiplier and divider widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int P1_W   = ALPHA_W + SAMPLE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Arithmetic constants
    localparam logic [ALPHA_W-1:0] ONE_Q16    = ALPHA_W'(65536);
    localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(32768);
    localparam int                 DIV_CONST  = 1000;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(50);
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = ALPHA_W'(6554);
    localparam logic [COEF_W-1:0]   VPC_RST    = COEF_W'(3277);
    localparam logic [COEF_W-1:0]   COND_RST   = COEF_W'(65536);

    typedef enum logic [1:0] {
        OP_SAMPLE       = 2'd0,
        OP_RESET_ENERGY = 2'd1,
        OP_FREEZE       = 2'd2,
        OP_UNFREEZE     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 3'd0,
        CFG_ALPHA  = 3'd1,
        CFG_VPC    = 3'd2,
        CFG_COND   = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ms;
        logic [ALPHA_W-1:0]  alpha;
        logic [COEF_W-1:0]   volts_per_count;
        logic [COEF_W-1:0]   load_conductance;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/epm_if.sv =====
`default_nettype none

// Input item channel
interface epm_item_if;
    import epm_pkg::*;
    logic                valid;
    logic                ready;
    t_op                 op;
    logic [SAMPLE_W-1:0] sample;
    logic [NOW_W-1:0]    now_ms;

    modport source (output valid, output op, output sample, output now_ms, input ready);
    modport sink   (input valid, input op, input sample, input now_ms, output ready);
endinterface

// Result channel
interface epm_result_if;
    import epm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [VOLT_W-1:0]       average_volts;
    logic [VOLT_W-1:0]       last_volts;
    logic [WATT_W-1:0]       average_watts;
    logic [ENERGY_OUT_W-1:0] energy_joules;
    logic                    is_frozen;
    logic                    sample_taken;

    modport source (output valid, output average_volts, output last_volts,
                    output average_watts, output energy_joules, output is_frozen,
                    output sample_taken, input ready);
    modport sink   (input valid, input average_volts, input last_volts,
                    input average_watts, input energy_joules, input is_frozen,
                    input sample_taken, output ready);
endinterface

// Configuration write channel
interface epm_cfg_if;
    import epm_pkg::*;
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/epm_cfg.sv =====
`default_nettype none

module epm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    epm_cfg_if.sink       i_cfg,
    output epm_pkg::t_cfg o_cfg
);
    import epm_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [COEF_W-1:0]   r_vpc;
    logic [COEF_W-1:0]   r_cond;

    assign i_cfg.ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_alpha  <= ALPHA_RST;
            r_vpc    <= VPC_RST;
            r_cond   <= COND_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PERIOD: r_period <= i_cfg.data[PERIOD_W-1:0];
                CFG_ALPHA:  r_alpha  <= i_cfg.data[ALPHA_W-1:0];
                CFG_VPC:    r_vpc    <= i_cfg.data[COEF_W-1:0];
                CFG_COND:   r_cond   <= i_cfg.data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the weight to one
    assign o_cfg.period_ms        = r_period;
    assign o_cfg.alpha            = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;
    assign o_cfg.volts_per_count  = r_vpc;
    assign o_cfg.load_conductance = r_cond;

endmodule

`default_nettype wire

// ===== design/epm_mul.sv =====
`default_nettype none

module epm_mul (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [epm_pkg::MUL_W-1:0]  i_a,
    input  logic [epm_pkg::MUL_W-1:0]  i_b,
    output logic [epm_pkg::PROD_W-1:0] o_prod
);
    import epm_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Register the full product, hold it between issues
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== design/epm_div.sv =====
`default_nettype none

module epm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [epm_pkg::PROD_W-1:0] i_dividend,
    output logic                       o_mul_en,
    output logic [epm_pkg::MUL_W-1:0]  o_mul_a,
    output logic [epm_pkg::MUL_W-1:0]  o_mul_b,
    input  logic [epm_pkg::PROD_W-1:0] i_prod,
    output logic                       o_done,
    output logic [epm_pkg::PROD_W-1:0] o_quotient
);
    import epm_pkg::*;

    // Long division in 16-bit digits. Each partial dividend stays below
    // 1000 * 2^16, so its quotient digit is the reciprocal product >> 36.
    localparam int DIGIT_W = 16;
    localparam int STEPS   = PROD_W / DIGIT_W;
    localparam int CNT_W   = $clog2(STEPS);
    localparam int REM_W   = $clog2(DIV_CONST);
    localparam int NUM_W   = REM_W + DIGIT_W;
    localparam int SHIFT   = NUM_W + REM_W;
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) / 64'(DIV_CONST)) + 64'd1);

    logic [PROD_W-1:0]  r_work;
    logic [REM_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_phase;
    logic               r_done;
    logic [NUM_W-1:0]   num;
    logic [DIGIT_W-1:0] digit_q;
    logic [NUM_W-1:0]   digit_back;
    logic [NUM_W-1:0]   digit_rem;

    // Bring the next dividend digit down beside the partial remainder
    assign num        = {r_rem, r_work[PROD_W-1 -: DIGIT_W]};
    // Quotient digit from the reciprocal product, remainder by subtraction
    assign digit_q    = i_prod[SHIFT +: DIGIT_W];
    assign digit_back = NUM_W'(digit_q) * NUM_W'(DIV_CONST);
    assign digit_rem  = num - digit_back;

    // Load on start; per digit issue the product, then shift the digit in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_work  <= i_dividend;
                r_rem   <= '0;
                r_cnt   <= CNT_W'(STEPS - 1);
                r_phase <= 1'b0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_work <= {r_work[PROD_W-DIGIT_W-1:0], digit_q};
                    r_rem  <= digit_rem[REM_W-1:0];
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_mul_en   = r_busy && !r_phase;
    assign o_mul_a    = MUL_W'(num);
    assign o_mul_b    = RECIP;
    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

`default_nettype wire

// ===== design/ema_power_energy_meter_unit.sv =====
`default_nettype none

// Channel  | Dir | Payload                                         | Transfer
// i_item   | in  | op, sample, now_ms                              | valid & ready
// o_result | out | average_volts, last_volts, average_watts,       | valid & ready
//          |     | energy_joules, is_frozen, sample_taken          |
// i_cfg    | in  | index, data                                     | valid & ready
//
// An accepted sample uses up to seven products on the shared 32x32 multiplier
// and the divide by 1000, worked as four 16-bit digits on that same
// multiplier. One item is worked at a time; i_item.ready is high only
// while the sequencer is idle. The result waits in an output register, so the
// next item is taken while it is still unread. Reset is synchronous; the
// configuration port is always ready.

module ema_power_energy_meter_unit #(
    parameter int ADC_BITS    = epm_pkg::ADC_BITS_DEF,
    parameter int ENERGY_BITS = epm_pkg::ENERGY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    epm_item_if.sink      i_item,
    epm_result_if.source  o_result,
    epm_cfg_if.sink       i_cfg
);
    import epm_pkg::*;

    localparam int AVG_W = ADC_BITS + FRAC_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int CAP_W = (ENERGY_BITS > ENERGY_OUT_W) ? ENERGY_BITS : ENERGY_OUT_W;
    localparam logic [SAMPLE_W-1:0] ADC_MASK   = SAMPLE_W'((33'd1 << ADC_BITS) - 33'd1);
    localparam logic [SUM_W-1:0]    ENERGY_MAX = SUM_W'({ENERGY_BITS{1'b1}});
    localparam logic [CAP_W-1:0]    OUT_MAX    = CAP_W'({ENERGY_OUT_W{1'b1}});

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_MUL_A, S_MUL_B, S_AVG, S_VOLTS, S_LASTV, S_SQ,
        S_WATTS, S_WCAP, S_MUL_E, S_DIV_GO, S_DIV, S_ADD, S_DONE
    } t_state;

    t_cfg cfg;

    // Sequencer and meter state
    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [SAMPLE_W-1:0]     r_smp, n_smp;
    logic [NOW_W-1:0]        r_now, n_now;
    logic [NOW_W-1:0]        r_elapsed, n_elapsed;
    logic                    r_taken, n_taken;
    logic [AVG_W-1:0]        r_avg, n_avg;
    logic [SAMPLE_W-1:0]     r_prev, n_prev;
    logic [ENERGY_BITS-1:0]  r_energy, n_energy;
    logic [NOW_W-1:0]        r_last_ms, n_last_ms;
    logic                    r_time_known, n_time_known;
    logic                    r_frozen, n_frozen;
    logic                    r_reload, n_reload;
    logic [P1_W-1:0]         r_p1, n_p1;
    logic [VOLT_W-1:0]       r_volts, n_volts;
    logic [VOLT_W-1:0]       r_last_volts, n_last_volts;
    logic [WATT_W-1:0]       r_watts, n_watts;

    // Output register
    logic                    r_out_valid, n_out_valid;
    logic [VOLT_W-1:0]       r_out_avg_volts, n_out_avg_volts;
    logic [VOLT_W-1:0]       r_out_last_volts, n_out_last_volts;
    logic [WATT_W-1:0]       r_out_watts, n_out_watts;
    logic [ENERGY_OUT_W-1:0] r_out_energy, n_out_energy;
    logic                    r_out_frozen, n_out_frozen;
    logic                    r_out_taken, n_out_taken;

    // Datapath signals
    logic [NOW_W-1:0]  elapsed_ms;
    logic              due;
    logic              mul_en;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] avg_sum;
    logic [SUM_W-1:0]  energy_sum;
    logic [CAP_W-1:0]  energy_cap;
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_quotient;
    logic              div_mul_en;
    logic [MUL_W-1:0]  div_mul_a;
    logic [MUL_W-1:0]  div_mul_b;

    epm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    epm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    epm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .o_mul_en   (div_mul_en),
        .o_mul_a    (div_mul_a),
        .o_mul_b    (div_mul_b),
        .i_prod     (prod),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Sample gating: period elapsed, period zero or no time yet
    assign elapsed_ms = r_now - r_last_ms;
    assign due        = (cfg.period_ms == '0) || (elapsed_ms >= NOW_W'(cfg.period_ms))
                        || !r_time_known;

    // Weighted sum with rounding, energy sum, output cap
    assign avg_sum    = PROD_W'({r_p1, {FRAC_W{1'b0}}}) + prod + ROUND_HALF;
    assign energy_sum = SUM_W'(r_energy) + SUM_W'(div_quotient);
    assign energy_cap = CAP_W'(r_energy);
    assign div_start  = (r_state == S_DIV_GO);

    // Operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MUL_A: begin
                mul_a = MUL_W'(cfg.alpha);
                mul_b = MUL_W'(r_smp);
            end
            S_MUL_B: begin
                mul_a = MUL_W'(ONE_Q16 - cfg.alpha);
                mul_b = MUL_W'(r_avg);
            end
            S_VOLTS: begin
                mul_a = MUL_W'(r_avg);
                mul_b = MUL_W'(cfg.volts_per_count);
            end
            S_LASTV: begin
                mul_a = MUL_W'(r_prev);
                mul_b = MUL_W'(cfg.volts_per_count);
            end
            S_SQ: begin
                mul_a = MUL_W'(r_volts);
                mul_b = MUL_W'(r_volts);
            end
            S_WATTS: begin
                mul_a = prod[FRAC_W +: WATT_W];
                mul_b = MUL_W'(cfg.load_conductance);
            end
            S_MUL_E: begin
                mul_a = MUL_W'(r_watts);
                mul_b = MUL_W'(r_elapsed);
            end
            S_DIV: begin
                mul_en = div_mul_en;
                mul_a  = div_mul_a;
                mul_b  = div_mul_b;
            end
            default: mul_en = 1'b0;
        endcase
    end

    // Next-state logic
    always_comb begin
        n_state          = r_state;
        n_op             = r_op;
        n_smp            = r_smp;
        n_now            = r_now;
        n_elapsed        = r_elapsed;
        n_taken          = r_taken;
        n_avg            = r_avg;
        n_prev           = r_prev;
        n_energy         = r_energy;
        n_last_ms        = r_last_ms;
        n_time_known     = r_time_known;
        n_frozen         = r_frozen;
        n_reload         = r_reload;
        n_p1             = r_p1;
        n_volts          = r_volts;
        n_last_volts     = r_last_volts;
        n_watts          = r_watts;
        n_out_valid      = r_out_valid;
        n_out_avg_volts  = r_out_avg_volts;
        n_out_last_volts = r_out_last_volts;
        n_out_watts      = r_out_watts;
        n_out_energy     = r_out_energy;
        n_out_frozen     = r_out_frozen;
        n_out_taken      = r_out_taken;

        // Drop the result once it is transferred
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op    = i_item.op;
                    n_smp   = i_item.sample & ADC_MASK;
                    n_now   = i_item.now_ms;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_taken   = 1'b0;
                n_elapsed = elapsed_ms;
                n_state   = S_VOLTS;
                case (r_op)
                    OP_SAMPLE: begin
                        if (due && !r_frozen) begin
                            n_taken      = 1'b1;
                            n_last_ms    = r_now;
                            n_time_known = 1'b1;
                            n_prev       = r_smp;
                            if (r_reload) begin
                                n_avg    = AVG_W'({r_smp, {FRAC_W{1'b0}}});
                                n_reload = 1'b0;
                            end else begin
                                n_state = S_MUL_A;
                            end
                        end
                    end
                    OP_RESET_ENERGY: begin
                        n_energy     = '0;
                        n_frozen     = 1'b0;
                        n_last_ms    = r_now;
                        n_time_known = 1'b1;
                    end
                    OP_FREEZE: n_frozen = 1'b1;
                    OP_UNFREEZE: begin
                        n_frozen = 1'b0;
                        n_reload = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_MUL_A: n_state = S_MUL_B;
            S_MUL_B: begin
                n_p1    = prod[P1_W-1:0];
                n_state = S_AVG;
            end
            S_AVG: begin
                n_avg   = avg_sum[FRAC_W +: AVG_W];
                n_state = S_VOLTS;
            end
            S_VOLTS: n_state = S_LASTV;
            S_LASTV: begin
                n_volts = (prod[PROD_W-1:FRAC_W+VOLT_W] != '0) ? '1
                          : prod[FRAC_W +: VOLT_W];
                n_state = S_SQ;
            end
            S_SQ: begin
                n_last_volts = (prod[PROD_W-1:VOLT_W] != '0) ? '1 : prod[VOLT_W-1:0];
                n_state      = S_WATTS;
            end
            S_WATTS: n_state = S_WCAP;
            S_WCAP: begin
                n_watts = (prod[PROD_W-1:FRAC_W+WATT_W] != '0) ? '1
                          : prod[FRAC_W +: WATT_W];
                n_state = r_taken ? S_MUL_E : S_DONE;
            end
            S_MUL_E:  n_state = S_DIV_GO;
            S_DIV_GO: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_energy = (energy_sum > ENERGY_MAX) ? ENERGY_MAX[ENERGY_BITS-1:0]
                           : energy_sum[ENERGY_BITS-1:0];
                n_state  = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid      = 1'b1;
                    n_out_avg_volts  = r_volts;
                    n_out_last_volts = r_last_volts;
                    n_out_watts      = r_watts;
                    n_out_energy     = (energy_cap > OUT_MAX) ? '1
                                       : energy_cap[ENERGY_OUT_W-1:0];
                    n_out_frozen     = r_frozen;
                    n_out_taken      = r_taken;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_taken      <= 1'b0;
            r_avg        <= '0;
            r_prev       <= '0;
            r_energy     <= '0;
            r_last_ms    <= '0;
            r_time_known <= 1'b0;
            r_frozen     <= 1'b0;
            r_reload     <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_taken      <= n_taken;
            r_avg        <= n_avg;
            r_prev       <= n_prev;
            r_energy     <= n_energy;
            r_last_ms    <= n_last_ms;
            r_time_known <= n_time_known;
            r_frozen     <= n_frozen;
            r_reload     <= n_reload;
            r_out_valid  <= n_out_valid;
        end
        r_op             <= n_op;
        r_smp            <= n_smp;
        r_now            <= n_now;
        r_elapsed        <= n_elapsed;
        r_p1             <= n_p1;
        r_volts          <= n_volts;
        r_last_volts     <= n_last_volts;
        r_watts          <= n_watts;
        r_out_avg_volts  <= n_out_avg_volts;
        r_out_last_volts <= n_out_last_volts;
        r_out_watts      <= n_out_watts;
        r_out_energy     <= n_out_energy;
        r_out_frozen     <= n_out_frozen;
        r_out_taken      <= n_out_taken;
    end

    assign i_item.ready           = (r_state == S_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.average_volts = r_out_avg_volts;
    assign o_result.last_volts    = r_out_last_volts;
    assign o_result.average_watts = r_out_watts;
    assign o_result.energy_joules = r_out_energy;
    assign o_result.is_frozen     = r_out_frozen;
    assign o_result.sample_taken  = r_out_taken;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");

    a_accept_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_state == S_DECIDE)
        else $error("accepted item did not reach decision");

    a_taken_is_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_taken) |-> r_op == OP_SAMPLE)
        else $error("non-sample item marked as taken");

    a_taken_not_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_frozen && r_out_taken))
        else $error("sample taken while frozen");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import epm_pkg::*;

    // Unused configuration index, must be ignored by the block
    localparam t_cfg_idx CFG_SPARE = t_cfg_idx'(7);

    localparam logic [63:0] ENERGY_CEIL = (64'd1 << ENERGY_BITS_DEF) - 64'd1;
    localparam logic [63:0] VOLT_CEIL   = (64'd1 << VOLT_W) - 64'd1;
    localparam logic [63:0] WATT_CEIL   = (64'd1 << WATT_W) - 64'd1;
    localparam logic [63:0] MS_PER_S    = 64'd1000;
    localparam int          SETTLE_CYC  = 64;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] smp;
        logic [NOW_W-1:0]    now;
    } t_meter_item;

    typedef struct packed {
        logic [VOLT_W-1:0]       avg_volts;
        logic [VOLT_W-1:0]       last_volts;
        logic [WATT_W-1:0]       watts;
        logic [ENERGY_OUT_W-1:0] energy;
        logic                    frozen;
        logic                    taken;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    epm_item_if   item_ch ();
    epm_result_if res_ch ();
    epm_cfg_if    cfg_ch ();

    ema_power_energy_meter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // Register shadow
    logic [PERIOD_W-1:0] m_period;
    logic [ALPHA_W-1:0]  m_alpha;
    logic [COEF_W-1:0]   m_vpc;
    logic [COEF_W-1:0]   m_cond;

    // Meter state shadow
    logic [SAMPLE_W+FRAC_W-1:0] m_avg;
    logic [SAMPLE_W-1:0]        m_prev;
    logic [ENERGY_OUT_W-1:0]    m_energy;
    logic [NOW_W-1:0]           m_last_ms;
    logic                       m_time_known;
    logic                       m_frozen;
    logic                       m_reload;

    t_meter_item item_backlog[$];
    t_reading    due_readings[$];

    t_meter_item next_item;
    t_reading    want_rd;
    t_reading    got_rd;
    int          burst_left;
    int          gap_left;
    int          hold_cnt;
    int          stall_mode;
    int          cycle_cnt;
    int          items_in;
    int          taken_cnt;
    int          readings_seen;
    int          setting_cnt;
    int          mismatch_cnt;
    logic [NOW_W-1:0] stamp_ms;

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] avg_volts_now();
        logic [63:0] v;
        v = (64'(m_avg) * 64'(m_vpc)) >> FRAC_W;
        return (v > VOLT_CEIL) ? VOLT_CEIL : v;
    endfunction

    function automatic logic [63:0] avg_watts_now();
        logic [63:0] v;
        logic [63:0] sq;
        logic [63:0] w;
        v  = avg_volts_now();
        sq = (v * v) >> FRAC_W;
        w  = (sq * 64'(m_cond)) >> FRAC_W;
        return (w > WATT_CEIL) ? WATT_CEIL : w;
    endfunction

    // Advance the meter shadow by one item and return the reading it yields
    function automatic t_reading meter_step(t_op op, logic [SAMPLE_W-1:0] smp,
                                            logic [NOW_W-1:0] now);
        t_reading         r;
        logic [NOW_W-1:0] elapsed;
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] a_rest;
        logic [63:0]      acc;
        logic [63:0]      inc;
        logic [63:0]      lv;
        logic             taken;
        taken   = 1'b0;
        elapsed = now - m_last_ms;
        case (op)
            OP_SAMPLE: begin
                if ((m_period == '0 || 32'(m_period) <= elapsed || !m_time_known)
                        && !m_frozen) begin
                    a      = (m_alpha > ONE_Q16) ? ONE_Q16 : m_alpha;
                    a_rest = ONE_Q16 - a;
                    m_last_ms    = now;
                    m_time_known = 1'b1;
                    m_prev       = smp;
                    if (m_reload) begin
                        m_avg    = {smp, 16'd0};
                        m_reload = 1'b0;
                    end else begin
                        acc   = 64'(a) * (64'(smp) << FRAC_W) + 64'(a_rest) * 64'(m_avg)
                              + 64'd32768;
                        m_avg = acc[FRAC_W +: SAMPLE_W+FRAC_W];
                    end
                    inc = (avg_watts_now() * 64'(elapsed)) / MS_PER_S;
                    if (inc > ENERGY_CEIL - 64'(m_energy)) m_energy = ENERGY_CEIL[47:0];
                    else m_energy = m_energy + inc[47:0];
                    taken = 1'b1;
                end
            end
            OP_RESET_ENERGY: begin
                m_energy     = '0;
                m_frozen     = 1'b0;
                m_last_ms    = now;
                m_time_known = 1'b1;
            end
            OP_FREEZE: m_frozen = 1'b1;
            default: begin
                m_frozen = 1'b0;
                m_reload = 1'b1;
            end
        endcase
        lv = 64'(m_prev) * 64'(m_vpc);
        r.avg_volts  = avg_volts_now();
        r.last_volts = (lv > VOLT_CEIL) ? VOLT_CEIL : lv;
        r.watts      = avg_watts_now();
        r.energy     = m_energy;
        r.frozen     = m_frozen;
        r.taken      = taken;
        return r;
    endfunction

    // Item driver: bursts of transfers with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                want_rd = meter_step(item_ch.op, item_ch.sample, item_ch.now_ms);
                due_readings.push_back(want_rd);
                items_in++;
                if (want_rd.taken) taken_cnt++;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (gap_left != 0 || item_backlog.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    item_ch.valid <= 1'b0;
                end else begin
                    next_item = item_backlog.pop_front();
                    item_ch.valid  <= 1'b1;
                    item_ch.op     <= next_item.op;
                    item_ch.sample <= next_item.smp;
                    item_ch.now_ms <= next_item.now;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                    end
                end
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_cnt   = 0;
            stall_mode = 0;
            cycle_cnt  = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                readings_seen++;
                got_rd.avg_volts  = res_ch.average_volts;
                got_rd.last_volts = res_ch.last_volts;
                got_rd.watts      = res_ch.average_watts;
                got_rd.energy     = res_ch.energy_joules;
                got_rd.frozen     = res_ch.is_frozen;
                got_rd.taken      = res_ch.sample_taken;
                if (due_readings.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("tb: reading %0d arrived with none pending", readings_seen);
                end else begin
                    want_rd = due_readings.pop_front();
                    if (got_rd.avg_volts !== want_rd.avg_volts
                            || got_rd.last_volts !== want_rd.last_volts
                            || got_rd.watts !== want_rd.watts
                            || got_rd.energy !== want_rd.energy
                            || got_rd.frozen !== want_rd.frozen
                            || got_rd.taken !== want_rd.taken) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("tb: reading %0d mismatch (expected / actual)",
                                     readings_seen);
                            $display("  avg_v %h/%h last_v %h/%h watts %h/%h",
                                     want_rd.avg_volts, got_rd.avg_volts,
                                     want_rd.last_volts, got_rd.last_volts,
                                     want_rd.watts, got_rd.watts);
                            $display("  energy %h/%h frozen %b/%b taken %b/%b",
                                     want_rd.energy, got_rd.energy,
                                     want_rd.frozen, got_rd.frozen,
                                     want_rd.taken, got_rd.taken);
                        end
                    end
                end
            end
            // switch stall behavior periodically
            cycle_cnt++;
            if (cycle_cnt % 1024 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (res_ch.valid && res_ch.ready) hold_cnt = $urandom_range(0, 120);
                    res_ch.ready <= (hold_cnt == 0);
                    if (hold_cnt > 0) hold_cnt--;
                end
            endcase
        end
    end

    // Write one register and update the shadow on transfer
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_PERIOD: m_period = value[PERIOD_W-1:0];
            CFG_ALPHA:  m_alpha  = value[ALPHA_W-1:0];
            CFG_VPC:    m_vpc    = value;
            CFG_COND:   m_cond   = value;
            default: ;
        endcase
    endtask

    // Write all four registers, with random filler in the unused data bits of period and weight
    task automatic set_regs(logic [PERIOD_W-1:0] period, logic [ALPHA_W-1:0] alpha,
                            logic [COEF_W-1:0] vpc, logic [COEF_W-1:0] cond);
        write_reg(CFG_PERIOD, {8'($urandom), period});
        write_reg(CFG_ALPHA, {7'($urandom), alpha});
        write_reg(CFG_VPC, vpc);
        write_reg(CFG_COND, cond);
        setting_cnt++;
    endtask

    task automatic push_item(t_op op, logic [SAMPLE_W-1:0] smp, logic [NOW_W-1:0] now);
        t_meter_item it;
        it.op  = op;
        it.smp = smp;
        it.now = now;
        stamp_ms = now;
        item_backlog.push_back(it);
    endtask

    // Hold until every queued item is transferred and every reading is back;
    // check on the falling edge so the driver's updates have settled
    task automatic drain();
        while (item_backlog.size() != 0 || item_ch.valid || due_readings.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic push_random_item();
        t_op              op;
        logic [NOW_W-1:0] step;
        logic [SAMPLE_W-1:0] smp;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 80)      op = OP_SAMPLE;
        else if (r < 87) op = OP_RESET_ENERGY;
        else if (r < 93) op = OP_FREEZE;
        else             op = OP_UNFREEZE;
        case ($urandom_range(0, 9))
            0:       step = '0;
            1, 2, 3: step = $urandom_range(0, 2 * int'(m_period) + 2);
            4, 5:    step = 32'(m_period) + $urandom_range(0, 3);
            6:       step = (m_period == '0) ? '0 : 32'(m_period) - 1;
            7, 8:    step = $urandom_range(0, 5000);
            default: step = $urandom();
        endcase
        r = $urandom_range(0, 9);
        if (r == 0)      smp = '0;
        else if (r == 1) smp = '1;
        else             smp = SAMPLE_W'($urandom());
        push_item(op, smp, stamp_ms + step);
    endtask

    // Drive all inputs, reset, then run the test phases
    initial begin
        logic [PERIOD_W-1:0] period;
        logic [ALPHA_W-1:0]  alpha;
        logic [COEF_W-1:0]   vpc;
        logic [COEF_W-1:0]   cond;
        int                  r;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.op     = OP_SAMPLE;
        item_ch.sample = '0;
        item_ch.now_ms = '0;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_PERIOD;
        cfg_ch.data    = '0;
        m_period       = PERIOD_RST;
        m_alpha        = ALPHA_RST;
        m_vpc          = VPC_RST;
        m_cond         = COND_RST;
        m_avg          = '0;
        m_prev         = '0;
        m_energy       = '0;
        m_last_ms      = '0;
        m_time_known   = 1'b0;
        m_frozen       = 1'b0;
        m_reload       = 1'b1;
        stamp_ms       = '0;
        items_in       = 0;
        taken_cnt      = 0;
        readings_seen  = 0;
        setting_cnt    = 1;
        mismatch_cnt   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: first sample, early and exact-period samples, freeze paths
        push_item(OP_SAMPLE, 10'h3FF, 32'd0);
        push_item(OP_SAMPLE, 10'h200, 32'd10);
        push_item(OP_SAMPLE, 10'h000, 32'd60);
        push_item(OP_SAMPLE, 10'h155, 32'd110);
        push_item(OP_FREEZE, 10'h000, 32'd200);
        push_item(OP_SAMPLE, 10'h2AA, 32'd400);
        push_item(OP_UNFREEZE, 10'h000, 32'd400);
        push_item(OP_SAMPLE, 10'd700, 32'd450);
        // timestamp wrap around zero
        push_item(OP_RESET_ENERGY, 10'h000, 32'hFFFF_FFF0);
        push_item(OP_SAMPLE, 10'd900, 32'h0000_0021);
        push_item(OP_SAMPLE, 10'd900, 32'h0000_0022);
        push_item(OP_FREEZE, 10'h000, 32'h0000_0030);
        push_item(OP_RESET_ENERGY, 10'h000, 32'h0000_0040);
        push_item(OP_SAMPLE, 10'h3FF, 32'hAAAA_AAAA);
        push_item(OP_SAMPLE, 10'h000, 32'h5555_5555);
        drain();

        // Extremes: zero period, full weight, largest scales, energy saturation
        set_regs('0, ONE_Q16, '1, '1);
        push_item(OP_SAMPLE, 10'h3FF, stamp_ms);
        push_item(OP_SAMPLE, 10'h000, stamp_ms);
        push_item(OP_SAMPLE, 10'h3FF, stamp_ms + 32'hFFFF_FFFF);
        push_item(OP_SAMPLE, 10'h3FF, stamp_ms);
        push_item(OP_RESET_ENERGY, 10'h000, stamp_ms + 1);
        push_item(OP_UNFREEZE, 10'h000, stamp_ms);
        push_item(OP_SAMPLE, 10'h1FF, stamp_ms);
        drain();

        // Longest period, weight above one, zero scales, spare register index
        set_regs('1, '1, '0, '0);
        write_reg(CFG_SPARE, '1);
        push_item(OP_SAMPLE, 10'h155, stamp_ms + 32'd65534);
        push_item(OP_SAMPLE, 10'h2AA, stamp_ms + 32'd65535);
        push_item(OP_SAMPLE, 10'h3FF, stamp_ms + 32'd65535);
        drain();

        // Random phases with random register settings
        repeat (8) begin
            r = $urandom_range(0, 9);
            if (r < 2)      period = '0;
            else if (r < 7) period = $urandom_range(1, 200);
            else if (r < 9) period = PERIOD_W'($urandom());
            else            period = '1;
            r = $urandom_range(0, 19);
            if (r < 2)       alpha = '0;
            else if (r < 10) alpha = $urandom_range(1, 10000);
            else if (r < 14) alpha = $urandom_range(0, 65536);
            else if (r < 17) alpha = ONE_Q16;
            else             alpha = $urandom_range(65537, 131071);
            r = $urandom_range(0, 9);
            if (r < 4)      vpc = $urandom_range(0, 70000);
            else if (r < 8) vpc = COEF_W'($urandom());
            else if (r < 9) vpc = '1;
            else            vpc = '0;
            r = $urandom_range(0, 9);
            if (r < 4)      cond = $urandom_range(0, 200000);
            else if (r < 8) cond = COEF_W'($urandom());
            else if (r < 9) cond = '1;
            else            cond = '0;
            set_regs(period, alpha, vpc, cond);
            repeat (210) push_random_item();
            drain();
        end

        // Let any stray reading surface before the verdict
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("tb: %0d items over %0d register settings, %0d readings checked",
                 items_in, setting_cnt, readings_seen);
        $display("tb: %0d samples taken, %0d ignored or control, %0d mismatches",
                 taken_cnt, items_in - taken_cnt, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== ema_power_energy_meter_unit.f =====
design/epm_pkg.sv
design/epm_if.sv
design/epm_cfg.sv
design/epm_mul.sv
design/epm_div.sv
design/ema_power_energy_meter_unit.sv
tb/tb.sv
